// ----- rtl/aat2_pkg.sv -----
// Shared types and constants for the approximate atan2 unit.
package aat2_pkg;

  localparam int unsigned DIV_W          = 17;
  localparam int unsigned QUO_W          = 17;
  localparam int unsigned STEPS_PER_STG  = 4;
  localparam int unsigned DIV_STG        = 4;
  localparam int unsigned R_FRAC_BITS    = 15;

  localparam logic [13:0]        C1_PI_4  = 14'd6434;
  localparam logic [14:0]        C2_3PI_4 = 15'd19302;
  localparam logic signed [15:0] ANG_MAX  = 16'sd25736;

  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [DIV_W-1:0] den;
    logic [QUO_W-1:0] quo;
    logic             neg;
    logic             ysign;
    logic             far;
    logic             zero;
  } aat2_div_t;

endpackage

// ----- rtl/aat2_if.sv -----
// Stream interfaces for coordinate beats and angle beats.
interface aat2_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] y_coord;
  logic signed [15:0] x_coord;

  modport source (output valid, output y_coord, output x_coord, input ready);
  modport sink   (input valid, input y_coord, input x_coord, output ready);
endinterface

interface aat2_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] angle;

  modport source (output valid, output angle, input ready);
  modport sink   (input valid, input angle, output ready);
endinterface

// ----- rtl/aat2_div_stage.sv -----
// Four restoring-division steps followed by a pipeline register.
module aat2_div_stage (
  input  logic               clk,
  input  logic               en,
  input  aat2_pkg::aat2_div_t d_in,
  output aat2_pkg::aat2_div_t d_out
);
  import aat2_pkg::*;

  aat2_div_t d_r;
  aat2_div_t d_nxt;

  always_comb begin
    logic [DIV_W:0] t;
    logic           ge;
    d_nxt = d_in;
    for (int i = 0; i < STEPS_PER_STG; i++) begin
      t  = {d_nxt.rem, 1'b0};
      ge = (t >= {1'b0, d_nxt.den});
      if (ge) begin
        t = t - {1'b0, d_nxt.den};
      end
      d_nxt.rem = t[DIV_W-1:0];
      d_nxt.quo = {d_nxt.quo[QUO_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_out = d_r;

endmodule

// ----- rtl/approx_atan2_unit.sv -----
// Pipelined linear-ratio four-quadrant arctangent, Q2.13 radians out.
//
//   channel | dir | beat payload            | handshake
//   in_ch   | in  | y_coord, x_coord (s16)  | valid/ready
//   out_ch  | out | angle (s16, Q2.13)      | valid/ready
//
// Seven register stages: operand prep, four divider stages of four quotient
// bits each, the pi/4 multiply, and the round/sign stage that feeds out_ch.
// One beat per cycle sustained while out_ch is ready.
// Reset clears the stage valid bits only; payload registers are not reset.
// A stage loads when it is empty or the stage after it moves, so bubbles
// close up under a stall and nothing is dropped or repeated.
module approx_atan2_unit (
  input  logic clk,
  input  logic rst_n,
  aat2_in_if.sink    in_ch,
  aat2_out_if.source out_ch
);
  import aat2_pkg::*;

  localparam int unsigned NSTG    = DIV_STG + 3;
  localparam int unsigned MUL_STG = DIV_STG + 1;
  localparam int unsigned OUT_STG = DIV_STG + 2;

  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  logic [NSTG-1:0] stg_rdy;

  aat2_div_t prep_nxt;
  aat2_div_t prep_r;
  aat2_div_t div_q [0:DIV_STG];

  logic signed [31:0] prod_r;
  logic signed [31:0] prod_nxt;
  logic               ysign_r;
  logic               far_r;
  logic               zero_r;
  logic signed [15:0] angle_r;
  logic signed [15:0] angle_nxt;

  always_comb begin
    stg_rdy[NSTG-1] = !vld_r[NSTG-1] || out_ch.ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      stg_rdy[i] = !vld_r[i] || stg_rdy[i+1];
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (stg_rdy[0]) begin
      vld_nxt[0] = in_ch.valid;
    end
    for (int i = 1; i < NSTG; i++) begin
      if (stg_rdy[i]) begin
        vld_nxt[i] = vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ch.ready = stg_rdy[0];

  // operand prep and the leading quotient bit
  always_comb begin
    logic signed [17:0] ys;
    logic signed [17:0] xs;
    logic signed [17:0] ay;
    logic signed [17:0] num;
    logic signed [17:0] den;
    logic signed [17:0] mag;
    logic               x_pos;
    logic               ge;
    ys    = 18'(in_ch.y_coord);
    xs    = 18'(in_ch.x_coord);
    ay    = ys[17] ? -ys : ys;
    x_pos = !in_ch.x_coord[15] && (in_ch.x_coord != '0);
    num   = x_pos ? (xs - ay) : (xs + ay);
    den   = x_pos ? (xs + ay) : (ay - xs);
    mag   = num[17] ? -num : num;
    ge    = (mag[DIV_W-1:0] >= den[DIV_W-1:0]);
    prep_nxt.den   = den[DIV_W-1:0];
    prep_nxt.rem   = ge ? (mag[DIV_W-1:0] - den[DIV_W-1:0]) : mag[DIV_W-1:0];
    prep_nxt.quo   = {{(QUO_W-1){1'b0}}, ge};
    prep_nxt.neg   = num[17];
    prep_nxt.ysign = in_ch.y_coord[15];
    prep_nxt.far   = !x_pos;
    prep_nxt.zero  = (in_ch.y_coord == '0) && (in_ch.x_coord == '0);
  end

  always_ff @(posedge clk) begin
    if (stg_rdy[0]) begin
      prep_r <= prep_nxt;
    end
  end

  assign div_q[0] = prep_r;

  for (genvar g = 0; g < DIV_STG; g++) begin : g_div
    aat2_div_stage u_div (
      .clk   (clk),
      .en    (stg_rdy[g+1]),
      .d_in  (div_q[g]),
      .d_out (div_q[g+1])
    );
  end

  // ratio times pi/4
  always_comb begin
    logic signed [16:0] r;
    logic        [15:0] q;
    logic signed [31:0] c1_w;
    logic signed [31:0] r_w;
    q        = div_q[DIV_STG].quo[QUO_W-1:1];
    r        = div_q[DIV_STG].neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    c1_w     = 32'($signed({1'b0, C1_PI_4}));
    r_w      = 32'(r);
    prod_nxt = c1_w * r_w;
  end

  always_ff @(posedge clk) begin
    if (stg_rdy[MUL_STG]) begin
      prod_r  <= prod_nxt;
      ysign_r <= div_q[DIV_STG].ysign;
      far_r   <= div_q[DIV_STG].far;
      zero_r  <= div_q[DIV_STG].zero;
    end
  end

  // subtract from base, clamp at zero, round half up, apply sign (zero for the origin)
  always_comb begin
    logic        [14:0] base;
    logic signed [31:0] v;
    logic        [31:0] sum;
    logic        [15:0] mag;
    base = far_r ? C2_3PI_4 : {1'b0, C1_PI_4};
    v    = $signed({2'b00, base, {R_FRAC_BITS{1'b0}}}) - prod_r;
    if (v[31]) begin
      v = '0;
    end
    sum  = v + (32'd1 << (R_FRAC_BITS - 1));
    mag  = sum[R_FRAC_BITS+15:R_FRAC_BITS];
    if (zero_r) begin
      angle_nxt = '0;
    end else if (ysign_r) begin
      angle_nxt = -$signed(mag);
    end else begin
      angle_nxt = $signed(mag);
    end
  end

  always_ff @(posedge clk) begin
    if (stg_rdy[OUT_STG]) begin
      angle_r <= angle_nxt;
    end
  end

  assign out_ch.valid = vld_r[OUT_STG];
  assign out_ch.angle = angle_r;

endmodule

// ----- rtl/aat2_chk.sv -----
// Port-level checks for the approximate atan2 unit, bound to the top level.
module aat2_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] angle
);
  import aat2_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(angle))
    else $error("angle beat changed or dropped while stalled");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (angle >= -ANG_MAX) && (angle <= ANG_MAX))
    else $error("angle outside -pi..pi");

  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output drains");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid && $past(!in_valid) && !out_valid && $past(!out_valid) |-> in_ready)
    else $error("input not ready with no traffic");

endmodule

bind approx_atan2_unit aat2_chk u_aat2_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .angle     (out_ch.angle)
);

// ----- dv/testbench.sv -----
// Self-checking testbench for approx_atan2_unit: predicted angles vs. stream output.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ANG_PI_4_Q13   = 6434;
  localparam int ANG_3PI_4_Q13  = 19302;
  localparam int RATIO_FRAC     = 15;
  localparam int DRAIN_CYCLES   = 12;
  localparam int MAX_IDLE       = 13;
  localparam int RANDOM_ITEMS   = 1700;

  typedef struct {
    logic signed [15:0] y_coord;
    logic signed [15:0] x_coord;
    logic signed [15:0] angle;
  } angle_entry_t;

  class angle_scoreboard;
    angle_entry_t pending_angles[$];
    int           errors;

    function new();
      errors = 0;
    endfunction

    function logic signed [15:0] atan2_q13(logic signed [15:0] y, logic signed [15:0] x);
      longint          sy, sx, ay, num, den, base, quo, v;
      longint unsigned mag;
      sy = y;
      sx = x;
      ay = (sy < 0) ? -sy : sy;
      if (sx == 0 && sy == 0) return 16'sd0;
      if (sx > 0) begin
        num  = sx - ay;
        den  = sx + ay;
        base = ANG_PI_4_Q13;
      end else begin
        num  = sx + ay;
        den  = ay - sx;
        base = ANG_3PI_4_Q13;
      end
      mag = (num < 0) ? longint'(-num) : longint'(num);
      quo = longint'((mag << RATIO_FRAC) / longint'(den));
      if (num < 0) quo = -quo;
      v = base * (longint'(1) << RATIO_FRAC) - ANG_PI_4_Q13 * quo;
      if (v < 0) v = 0;
      v = (v + (longint'(1) << (RATIO_FRAC - 1))) >>> RATIO_FRAC;
      if (sy < 0) v = -v;
      return v[15:0];
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    function void note_coord(logic signed [15:0] y, logic signed [15:0] x);
      angle_entry_t e;
      e.y_coord = y;
      e.x_coord = x;
      e.angle   = atan2_q13(y, x);
      pending_angles.push_back(e);
    endfunction

    task check_angle(logic signed [15:0] got);
      angle_entry_t e;
      if (pending_angles.size() == 0) begin
        report($sformatf("angle beat %0d with nothing pending", got));
      end else begin
        e = pending_angles.pop_front();
        if (got !== e.angle)
          report($sformatf("y=%0d x=%0d angle got %0d want %0d",
                           e.y_coord, e.x_coord, got, e.angle));
      end
    endtask

    function int pending_count();
      return pending_angles.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic src_quiet;
  logic sink_quiet;

  aat2_in_if  coord_ch();
  aat2_out_if angle_ch();

  angle_scoreboard sb;

  approx_atan2_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (coord_ch.sink),
    .out_ch (angle_ch.source)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("FAIL approx_atan2_unit");
    $finish;
  end

  function automatic int pick_idle(logic quiet);
    return quiet ? 0 : int'($urandom_range(0, MAX_IDLE));
  endfunction

  function automatic logic signed [15:0] corner_value();
    case ($urandom_range(0, 6))
      0: return -16'sd32768;
      1: return -16'sd32767;
      2: return -16'sd1;
      3: return 16'sd0;
      4: return 16'sd1;
      5: return 16'sd32766;
      default: return 16'sd32767;
    endcase
  endfunction

  task send_coord(input logic signed [15:0] y, input logic signed [15:0] x);
    int gap;
    gap = pick_idle(src_quiet);
    if (gap > 0) begin
      coord_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    coord_ch.valid   <= 1'b1;
    coord_ch.y_coord <= y;
    coord_ch.x_coord <= x;
    do @(posedge clk); while (coord_ch.ready !== 1'b1);
    sb.note_coord(y, x);
    if ($urandom_range(0, 39) == 0) src_quiet = ~src_quiet;
  endtask

  task send_random_coord();
    logic signed [15:0] y, x;
    case ($urandom_range(0, 9))
      5: begin
        y = 16'($urandom_range(0, 16) - 8);
        x = 16'($urandom_range(0, 16) - 8);
      end
      6: begin
        y = $urandom_range(0, 1) ? 16'(0) : 16'($urandom);
        x = (y == 0) ? 16'($urandom) : 16'(0);
      end
      7: begin
        y = corner_value();
        x = corner_value();
      end
      8: begin
        x = 16'($urandom);
        y = 16'(($urandom_range(0, 1) ? x : -x) + ($urandom_range(0, 4) - 2));
      end
      9: begin
        y = $urandom_range(0, 1) ? corner_value() : 16'($urandom_range(0, 6) - 3);
        x = $urandom_range(0, 1) ? corner_value() : 16'($urandom_range(0, 6) - 3);
      end
      default: begin
        y = 16'($urandom);
        x = 16'($urandom);
      end
    endcase
    send_coord(y, x);
  endtask

  task take_angles();
    int stall;
    int beats;
    beats = 0;
    forever begin
      stall = pick_idle(sink_quiet);
      if (stall > 0) begin
        angle_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      angle_ch.ready <= 1'b1;
      do @(posedge clk); while (angle_ch.valid !== 1'b1);
      sb.check_angle(angle_ch.angle);
      beats++;
      if ($urandom_range(0, 49) == 0) sink_quiet = ~sink_quiet;
    end
  endtask

  initial begin
    sb         = new();
    src_quiet  = 1'b0;
    sink_quiet = 1'b0;
    rst_n            <= 1'b0;
    coord_ch.valid   <= 1'b0;
    coord_ch.y_coord <= '0;
    coord_ch.x_coord <= '0;
    angle_ch.ready   <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    fork
      take_angles();
    join_none

    send_coord(16'sd0, 16'sd0);
    send_coord(16'sd0, 16'sd32767);
    send_coord(16'sd0, -16'sd32768);
    send_coord(16'sd0, -16'sd1);
    send_coord(16'sd0, 16'sd1);
    send_coord(16'sd32767, 16'sd0);
    send_coord(-16'sd32768, 16'sd0);
    send_coord(16'sd1, 16'sd0);
    send_coord(-16'sd1, 16'sd0);
    send_coord(16'sd32767, 16'sd32767);
    send_coord(-16'sd32768, -16'sd32768);
    send_coord(-16'sd32768, 16'sd32767);
    send_coord(16'sd32767, -16'sd32768);
    send_coord(16'sd1, 16'sd1);
    send_coord(-16'sd1, -16'sd1);
    send_coord(16'sd1, -16'sd1);
    send_coord(-16'sd1, 16'sd1);
    send_coord(-16'sd32768, -16'sd1);
    send_coord(16'sd1, -16'sd32768);
    send_coord(-16'sd1, 16'sd32767);
    send_coord(16'sd32767, 16'sd1);
    send_coord(16'sd5, -16'sd3);

    for (int i = 0; i < RANDOM_ITEMS; i++) send_random_coord();

    coord_ch.valid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_count() == 0) begin
      $display("PASS approx_atan2_unit");
    end else begin
      $display("FAIL approx_atan2_unit");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/aat2_pkg.sv
rtl/aat2_if.sv
rtl/aat2_div_stage.sv
rtl/approx_atan2_unit.sv
rtl/aat2_chk.sv
dv/testbench.sv
